>>> hdl/atlb_pkg.sv
// Shared types and constants for the address-space tagged translation buffer.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package atlb_pkg;

  localparam int unsigned EntriesDef = 64;
  localparam int unsigned VpnBits    = 30;
  localparam int unsigned PpnBits    = 32;
  localparam int unsigned AsnBits    = 8;
  localparam int unsigned CmdBits    = 3;

  typedef enum logic [CmdBits-1:0] {
    CmdLookup         = 3'd0,
    CmdInsert         = 3'd1,
    CmdFlushAll       = 3'd2,
    CmdFlushNonGlobal = 3'd3,
    CmdFlushPage      = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [CmdBits-1:0] cmd;
    logic [VpnBits-1:0] vpn;
    logic [AsnBits-1:0] asn;
    logic [PpnBits-1:0] ppn;
    logic               global_page;
    logic [3:0]         read_enables;
    logic [3:0]         write_enables;
    logic               fault_read;
    logic               fault_write;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [PpnBits-1:0] out_ppn;
    logic               out_global;
    logic [3:0]         out_read_enables;
    logic [3:0]         out_write_enables;
    logic               out_fault_read;
    logic               out_fault_write;
  } rsp_t;

  // Per-entry attribute bits, kept together in the entry store.
  typedef struct packed {
    logic       fault_write;
    logic       fault_read;
    logic [3:0] write_enables;
    logic [3:0] read_enables;
    logic       global_page;
  } flags_t;

  // Request held in the input register, with its valid bit.
  typedef struct packed {
    logic valid;
    req_t req;
  } op_t;

endpackage

>>> hdl/atlb_entries.sv
// Entry store of the translation buffer: tags, space numbers, pages, flags,
// valid bits and the round-robin replacement pointer. Uses atlb_pkg.
`timescale 1ns / 1ps

module atlb_entries
  import atlb_pkg::*;
#(
  parameter int unsigned ENTRIES = EntriesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  op_t                op_i,
  output logic [ENTRIES-1:0] match_o,
  output logic [PpnBits-1:0] page_o  [ENTRIES],
  output flags_t             flags_o [ENTRIES]
);

  localparam int unsigned PtrW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [VpnBits-1:0] tag_q   [ENTRIES];
  logic [AsnBits-1:0] space_q [ENTRIES];
  logic [PpnBits-1:0] page_q  [ENTRIES];
  flags_t             flags_q [ENTRIES];
  logic [PtrW-1:0]    ptr_q, ptr_d;
  logic               do_insert;
  flags_t             new_flags;

  assign do_insert = op_i.valid && (op_i.req.cmd == CmdInsert);

  assign new_flags = '{
    fault_write:   op_i.req.fault_write,
    fault_read:    op_i.req.fault_read,
    write_enables: op_i.req.write_enables,
    read_enables:  op_i.req.read_enables,
    global_page:   op_i.req.global_page
  };

  // All slots are compared in parallel against the pending request.
  always_comb begin
    for (int s = 0; s < ENTRIES; s++) begin
      match_o[s] = valid_q[s] && (tag_q[s] == op_i.req.vpn) &&
                   (flags_q[s].global_page || (space_q[s] == op_i.req.asn));
      page_o[s]  = page_q[s];
      flags_o[s] = flags_q[s];
    end
  end

  always_comb begin
    valid_d = valid_q;
    ptr_d   = ptr_q;
    if (op_i.valid) begin
      unique case (op_i.req.cmd)
        CmdInsert: begin
          valid_d[ptr_q] = 1'b1;
          ptr_d = (ptr_q == PtrW'(ENTRIES - 1)) ? '0 : ptr_q + PtrW'(1);
        end
        CmdFlushAll: begin
          valid_d = '0;
          ptr_d   = '0;
        end
        CmdFlushNonGlobal: begin
          for (int s = 0; s < ENTRIES; s++) begin
            if (!flags_q[s].global_page) begin
              valid_d[s] = 1'b0;
            end
          end
        end
        CmdFlushPage: begin
          valid_d = valid_q & ~match_o;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ptr_q   <= '0;
    end else begin
      valid_q <= valid_d;
      ptr_q   <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_insert) begin
      tag_q[ptr_q]   <= op_i.req.vpn;
      space_q[ptr_q] <= op_i.req.asn;
      page_q[ptr_q]  <= op_i.req.ppn;
      flags_q[ptr_q] <= new_flags;
    end
  end

endmodule

>>> hdl/atlb_select.sv
// Lowest-slot priority select over the match vector and the result mux.
// Uses atlb_pkg.
`timescale 1ns / 1ps

module atlb_select
  import atlb_pkg::*;
#(
  parameter int unsigned ENTRIES = EntriesDef
) (
  input  op_t                op_i,
  input  logic [ENTRIES-1:0] match_i,
  input  logic [PpnBits-1:0] page_i  [ENTRIES],
  input  flags_t             flags_i [ENTRIES],
  output rsp_t               rsp_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [IdxW-1:0] idx;
  logic            any_match;
  flags_t          sel_flags;

  // Scanning from the top down leaves the lowest matching slot selected.
  always_comb begin
    idx = '0;
    for (int s = ENTRIES - 1; s >= 0; s--) begin
      if (match_i[s]) begin
        idx = IdxW'(s);
      end
    end
  end

  assign any_match = |match_i;
  assign sel_flags = flags_i[idx];

  always_comb begin
    rsp_o = '0;
    if (op_i.req.cmd == CmdLookup && any_match) begin
      rsp_o.hit               = 1'b1;
      rsp_o.out_ppn           = page_i[idx];
      rsp_o.out_global        = sel_flags.global_page;
      rsp_o.out_read_enables  = sel_flags.read_enables;
      rsp_o.out_write_enables = sel_flags.write_enables;
      rsp_o.out_fault_read    = sel_flags.fault_read;
      rsp_o.out_fault_write   = sel_flags.fault_write;
    end
  end

endmodule

>>> hdl/asid_tagged_tlb.sv
// Top level of the address-space tagged translation buffer: input and result
// registers around the entry store and the select logic. Uses atlb_pkg.
`timescale 1ns / 1ps

// A request is taken in every cycle that start_i is high; busy_o stays low.
// Each request gives exactly one result. It is shown on rsp_o with
// result_valid_o for one cycle, out of the result register that follows the
// request register. The receiver cannot hold results off, and results come
// in request order.
// The throughput is one request per cycle: the request register feeds a
// parallel compare of all slots, a lowest-slot select and the result
// register, and state updates land at the same edge, so the next request
// sees them. Misses and commands other than lookup return all zeros.
module asid_tagged_tlb
  import atlb_pkg::*;
#(
  parameter int unsigned ENTRIES = EntriesDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  req_t req_i,
  output logic result_valid_o,
  output rsp_t rsp_o
);

  op_t                op_q;
  logic               op_valid_q;
  req_t               req_q;
  logic [ENTRIES-1:0] match;
  logic [PpnBits-1:0] page  [ENTRIES];
  flags_t             flags [ENTRIES];
  rsp_t               rsp_d, rsp_q;
  logic               result_valid_q;

  assign busy_o = 1'b0;
  assign op_q   = '{valid: op_valid_q, req: req_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_valid_q     <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      op_valid_q     <= start_i && !busy_o;
      result_valid_q <= op_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      req_q <= req_i;
    end
    if (op_valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  atlb_entries #(
    .ENTRIES(ENTRIES)
  ) u_entries (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (op_q),
    .match_o(match),
    .page_o (page),
    .flags_o(flags)
  );

  atlb_select #(
    .ENTRIES(ENTRIES)
  ) u_select (
    .op_i   (op_q),
    .match_i(match),
    .page_i (page),
    .flags_i(flags),
    .rsp_o  (rsp_d)
  );

  assign result_valid_o = result_valid_q;
  assign rsp_o          = rsp_q;

endmodule

>>> hdl/atlb_checker.sv
// Port-level checks for the translation buffer, bound to the top level.
// Uses atlb_pkg.
`timescale 1ns / 1ps

module atlb_checker
  import atlb_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input req_t req_i,
  input logic result_valid_o,
  input rsp_t rsp_o
);

  logic accepted;
  assign accepted = start_i && !busy_o;

  // Every request yields its result through the request and result registers, and nothing else does.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accepted |-> ##2 result_valid_o)
    else $error("request without result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(accepted, 2))
    else $error("result without request");

  // Only a lookup can report a hit.
  a_hit_from_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && rsp_o.hit) |-> ($past(req_i.cmd, 2) == CmdLookup))
    else $error("hit on a non-lookup request");

  a_miss_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !rsp_o.hit) |-> (rsp_o == '0))
    else $error("miss with nonzero fields");

  // A lookup right after a full flush must miss.
  a_flush_then_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accepted && req_i.cmd == CmdFlushAll) ##1 (accepted && req_i.cmd == CmdLookup)
      |=> ##1 !rsp_o.hit)
    else $error("hit after flush all");

endmodule

bind asid_tagged_tlb atlb_checker u_atlb_checker (.*);

>>> dv/atlb_checker.sv
// Checker for the address-space tagged translation buffer: watches the request
// and result channels, keeps its own copy of the entry table and compares.
// Depends on atlb_pkg for the request, result and flag types.
`timescale 1ns / 1ps

module atlb_tb_checker
  import atlb_pkg::*;
#(
  parameter int unsigned ENTRIES = EntriesDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic busy_i,
  input  req_t req_i,
  input  logic result_valid_i,
  input  rsp_t rsp_i,
  output int   fail_count_o,
  output int   outstanding_o,
  output int   requests_o,
  output int   lookups_o,
  output int   hits_o,
  output int   inserts_o,
  output int   flushes_o
);

  localparam int MaxPrinted = 50;

  logic               slot_valid [ENTRIES];
  logic [VpnBits-1:0] slot_tag   [ENTRIES];
  logic [AsnBits-1:0] slot_asn   [ENTRIES];
  logic [PpnBits-1:0] slot_ppn   [ENTRIES];
  flags_t             slot_flags [ENTRIES];
  int unsigned        victim;

  rsp_t expected_rsp_q[$];

  int n_errors;
  int n_requests;
  int n_lookups;
  int n_hits;
  int n_inserts;
  int n_flushes;

  assign fail_count_o = n_errors;
  assign requests_o   = n_requests;
  assign lookups_o    = n_lookups;
  assign hits_o       = n_hits;
  assign inserts_o    = n_inserts;
  assign flushes_o    = n_flushes;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    n_errors++;
    if (n_errors <= MaxPrinted) begin
      $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    end
  endtask

  function automatic void clear_table();
    for (int s = 0; s < ENTRIES; s++) begin
      slot_valid[s] = 1'b0;
      slot_tag[s]   = '0;
      slot_asn[s]   = '0;
      slot_ppn[s]   = '0;
      slot_flags[s] = '0;
    end
    victim = 0;
  endfunction

  function automatic bit slot_hits(input int s, input logic [VpnBits-1:0] vpn,
                                   input logic [AsnBits-1:0] asn);
    return slot_valid[s] && slot_tag[s] == vpn
        && (slot_flags[s].global_page || slot_asn[s] == asn);
  endfunction

  // Applies one request to the table copy and returns the result it gives.
  function automatic rsp_t translate(input req_t r);
    rsp_t rsp;
    bit   found;
    rsp   = '0;
    found = 1'b0;
    case (r.cmd)
      CmdLookup: begin
        // Duplicate matches resolve to the lowest slot.
        for (int s = 0; s < ENTRIES; s++) begin
          if (!found && slot_hits(s, r.vpn, r.asn)) begin
            found                 = 1'b1;
            rsp.hit               = 1'b1;
            rsp.out_ppn           = slot_ppn[s];
            rsp.out_global        = slot_flags[s].global_page;
            rsp.out_read_enables  = slot_flags[s].read_enables;
            rsp.out_write_enables = slot_flags[s].write_enables;
            rsp.out_fault_read    = slot_flags[s].fault_read;
            rsp.out_fault_write   = slot_flags[s].fault_write;
          end
        end
      end
      CmdInsert: begin
        slot_valid[victim]               = 1'b1;
        slot_tag[victim]                 = r.vpn;
        slot_asn[victim]                 = r.asn;
        slot_ppn[victim]                 = r.ppn;
        slot_flags[victim].global_page   = r.global_page;
        slot_flags[victim].read_enables  = r.read_enables;
        slot_flags[victim].write_enables = r.write_enables;
        slot_flags[victim].fault_read    = r.fault_read;
        slot_flags[victim].fault_write   = r.fault_write;
        victim = (victim == ENTRIES - 1) ? 0 : victim + 1;
      end
      CmdFlushAll: begin
        clear_table();
      end
      CmdFlushNonGlobal: begin
        for (int s = 0; s < ENTRIES; s++) begin
          if (!slot_flags[s].global_page) begin
            slot_valid[s] = 1'b0;
          end
        end
      end
      CmdFlushPage: begin
        for (int s = 0; s < ENTRIES; s++) begin
          if (slot_hits(s, r.vpn, r.asn)) begin
            slot_valid[s] = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
    return rsp;
  endfunction

  task automatic check_result(input rsp_t got, input rsp_t want);
    if (got.hit !== want.hit) begin
      report_mismatch("hit", 64'(got.hit), 64'(want.hit));
    end
    if (got.out_ppn !== want.out_ppn) begin
      report_mismatch("out_ppn", 64'(got.out_ppn), 64'(want.out_ppn));
    end
    if (got.out_global !== want.out_global) begin
      report_mismatch("out_global", 64'(got.out_global), 64'(want.out_global));
    end
    if (got.out_read_enables !== want.out_read_enables) begin
      report_mismatch("out_read_enables", 64'(got.out_read_enables),
                      64'(want.out_read_enables));
    end
    if (got.out_write_enables !== want.out_write_enables) begin
      report_mismatch("out_write_enables", 64'(got.out_write_enables),
                      64'(want.out_write_enables));
    end
    if (got.out_fault_read !== want.out_fault_read) begin
      report_mismatch("out_fault_read", 64'(got.out_fault_read),
                      64'(want.out_fault_read));
    end
    if (got.out_fault_write !== want.out_fault_write) begin
      report_mismatch("out_fault_write", 64'(got.out_fault_write),
                      64'(want.out_fault_write));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_table();
      expected_rsp_q.delete();
      outstanding_o <= 0;
    end else begin
      if (result_valid_i) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("unexpected result", 64'(rsp_i), '0);
        end else begin
          check_result(rsp_i, expected_rsp_q.pop_front());
        end
      end
      if (start_i && !busy_i) begin
        rsp_t want;
        want = translate(req_i);
        expected_rsp_q.push_back(want);
        n_requests++;
        if (req_i.cmd == CmdLookup) begin
          n_lookups++;
          if (want.hit) begin
            n_hits++;
          end
        end else if (req_i.cmd == CmdInsert) begin
          n_inserts++;
        end else if (req_i.cmd == CmdFlushAll || req_i.cmd == CmdFlushNonGlobal
                     || req_i.cmd == CmdFlushPage) begin
          n_flushes++;
        end
      end
      outstanding_o <= expected_rsp_q.size();
    end
  end

endmodule

>>> dv/asid_tagged_tlb_test.sv
// Top of the translation buffer testbench: clock, reset, request stimulus and
// the final verdict. Instantiates asid_tagged_tlb and atlb_tb_checker; uses atlb_pkg.
`timescale 1ns / 1ps

module asid_tagged_tlb_test;
  import atlb_pkg::*;

  localparam logic [CmdBits-1:0] CmdReservedFirst = CmdBits'(CmdFlushPage + 1);
  localparam logic [CmdBits-1:0] CmdReservedLast  = '1;
  localparam int PhaseItems    = 350;
  localparam int WatchdogLimit = 2000;
  localparam int VpnPoolSize   = 12;
  localparam int AsnPoolSize   = 4;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  req_t req_i;
  logic result_valid_o;
  rsp_t rsp_o;

  int fail_count;
  int outstanding;
  int n_requests;
  int n_lookups;
  int n_hits;
  int n_inserts;
  int n_flushes;
  int quiet_cycles;

  logic [VpnBits-1:0] vpn_pool [VpnPoolSize];
  logic [AsnBits-1:0] asn_pool [AsnPoolSize];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  asid_tagged_tlb dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o)
  );

  atlb_tb_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .req_i          (req_i),
    .result_valid_i (result_valid_o),
    .rsp_i          (rsp_o),
    .fail_count_o   (fail_count),
    .outstanding_o  (outstanding),
    .requests_o     (n_requests),
    .lookups_o      (n_lookups),
    .hits_o         (n_hits),
    .inserts_o      (n_inserts),
    .flushes_o      (n_flushes)
  );

  // Ends the run when neither a request nor a result moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || result_valid_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WatchdogLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic req_t make_req(input logic [CmdBits-1:0] cmd,
                                    input logic [VpnBits-1:0] vpn,
                                    input logic [AsnBits-1:0] asn,
                                    input logic [PpnBits-1:0] ppn,
                                    input flags_t f);
    req_t r;
    r.cmd           = cmd;
    r.vpn           = vpn;
    r.asn           = asn;
    r.ppn           = ppn;
    r.global_page   = f.global_page;
    r.read_enables  = f.read_enables;
    r.write_enables = f.write_enables;
    r.fault_read    = f.fault_read;
    r.fault_write   = f.fault_write;
    return r;
  endfunction

  function automatic req_t random_request();
    req_t        r;
    int unsigned pick;
    pick = $urandom_range(199);
    if (pick < 90) begin
      r.cmd = CmdLookup;
    end else if (pick < 160) begin
      r.cmd = CmdInsert;
    end else if (pick < 178) begin
      r.cmd = CmdFlushPage;
    end else if (pick < 188) begin
      r.cmd = CmdFlushNonGlobal;
    end else if (pick < 189) begin
      r.cmd = CmdFlushAll;
    end else begin
      r.cmd = CmdBits'($urandom_range(CmdReservedLast, CmdReservedFirst));
    end
    // Most pages and spaces come from small pools so that lookups and page
    // flushes find the entries that earlier inserts wrote.
    if ($urandom_range(99) < 85) begin
      r.vpn = vpn_pool[$urandom_range(VpnPoolSize - 1)];
    end else begin
      r.vpn = VpnBits'($urandom);
    end
    if ($urandom_range(99) < 85) begin
      r.asn = asn_pool[$urandom_range(AsnPoolSize - 1)];
    end else begin
      r.asn = AsnBits'($urandom);
    end
    r.ppn           = PpnBits'($urandom);
    r.global_page   = ($urandom_range(3) == 0);
    r.read_enables  = 4'($urandom);
    r.write_enables = 4'($urandom);
    r.fault_read    = 1'($urandom);
    r.fault_write   = 1'($urandom);
    return r;
  endfunction

  task automatic send(input req_t r, input int unsigned idle_pct);
    logic [95:0] noise;
    while ($urandom_range(99) < idle_pct) begin
      noise   = {$urandom, $urandom, $urandom};
      start_i <= 1'b0;
      req_i   <= noise[$bits(req_t)-1:0];
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= r;
    @(posedge clk_i);
    while (busy_o) begin
      @(posedge clk_i);
    end
  endtask

  // Holds off new requests until every expected result has come back.
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    logic [VpnBits-1:0] page_a;
    logic [VpnBits-1:0] page_b;
    flags_t             all_set;
    flags_t             no_flags;
    flags_t             global_mixed;
    flags_t             local_mixed;
    int unsigned        idle_profile [4];

    rst_ni  <= 1'b0;
    start_i <= 1'b0;
    req_i   <= '0;

    vpn_pool[0] = '0;
    vpn_pool[1] = '1;
    for (int i = 2; i < VpnPoolSize; i++) begin
      vpn_pool[i] = VpnBits'($urandom);
    end
    asn_pool[0] = '0;
    asn_pool[1] = '1;
    asn_pool[2] = AsnBits'($urandom);
    asn_pool[3] = AsnBits'($urandom);

    page_a       = 30'h2AAA_5555;
    page_b       = 30'h1555_AAAA;
    all_set      = '1;
    all_set.global_page = 1'b0;
    no_flags     = '0;
    global_mixed = flags_t'(11'h2B5);
    global_mixed.global_page = 1'b1;
    local_mixed  = flags_t'(11'h54A);
    local_mixed.global_page = 1'b0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty table, field extremes, space matching, global
    // entries, duplicate tags, each flush kind and the unused commands.
    send(make_req(CmdLookup, '0, '0, '0, no_flags), 0);
    send(make_req(CmdInsert, '1, '1, '1, all_set), 0);
    send(make_req(CmdInsert, '0, '0, '0, no_flags), 0);
    send(make_req(CmdLookup, '1, '1, '0, no_flags), 0);
    send(make_req(CmdLookup, '1, '0, '0, no_flags), 0);
    send(make_req(CmdLookup, '0, '0, '1, all_set), 0);
    send(make_req(CmdInsert, page_a, 8'd5, 32'hA5A5_A5A5, global_mixed), 0);
    send(make_req(CmdLookup, page_a, 8'd200, '0, no_flags), 0);
    send(make_req(CmdInsert, page_b, 8'd7, 32'h1234_5678, local_mixed), 0);
    send(make_req(CmdInsert, page_b, 8'd7, 32'h8765_4321, all_set), 0);
    send(make_req(CmdLookup, page_b, 8'd7, '0, no_flags), 0);
    send(make_req(CmdFlushPage, page_b, 8'd7, '0, no_flags), 0);
    send(make_req(CmdLookup, page_b, 8'd7, '0, no_flags), 0);
    send(make_req(CmdFlushPage, page_a, 8'd9, '0, no_flags), 0);
    send(make_req(CmdLookup, page_a, 8'd5, '0, no_flags), 0);
    send(make_req(CmdInsert, page_a, 8'd3, 32'h0F0F_F0F0, global_mixed), 0);
    send(make_req(CmdFlushNonGlobal, '1, '1, '1, all_set), 0);
    send(make_req(CmdLookup, '1, '1, '0, no_flags), 0);
    send(make_req(CmdLookup, page_a, 8'd0, '0, no_flags), 0);
    for (int c = CmdReservedFirst; c <= CmdReservedLast; c++) begin
      send(make_req(CmdBits'(c), page_a, 8'd3, PpnBits'($urandom), all_set), 0);
    end
    send(make_req(CmdLookup, page_a, 8'd1, '0, no_flags), 0);
    send(make_req(CmdFlushAll, page_a, 8'd3, '0, no_flags), 0);
    send(make_req(CmdLookup, page_a, 8'd3, '0, no_flags), 0);
    drain();

    idle_profile[0] = 0;
    idle_profile[1] = 88;
    idle_profile[2] = 22;
    idle_profile[3] = 0;
    for (int p = 0; p < 4; p++) begin
      for (int i = 0; i < PhaseItems; i++) begin
        send(random_request(), idle_profile[p]);
      end
      drain();
    end

    repeat (4) @(posedge clk_i);
    $display("covered %0d requests: %0d lookups (%0d hits), %0d inserts, %0d flushes",
             n_requests, n_lookups, n_hits, n_inserts, n_flushes);
    $display("sender idle profiles of 0, 88 and 22 percent, with drains between them");
    if (fail_count == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
